// ===== hw/rtl/pdst_pkg.sv =====
// ----------------------------------------------------------------------------
// pdst_pkg
// Types, constants and saturation helpers for the PnL drawdown/Sharpe tracker.
// ----------------------------------------------------------------------------
package pdst_pkg;

  localparam int unsigned FRAC_BITS   = 16;
  localparam int unsigned PNL_W       = 48;
  localparam int unsigned SHARPE_W    = 24;
  localparam int unsigned SHARPE_FRAC = 16;

  localparam logic signed [63:0] PNL_MAX_64 = (64'sd1 <<< (PNL_W - 1)) - 64'sd1;
  localparam logic signed [63:0] PNL_MIN_64 = -PNL_MAX_64 - 64'sd1;
  localparam logic [SHARPE_W-1:0] SHARPE_LIM = SHARPE_W'(1) << (SHARPE_W - 1);

  typedef struct packed {
    logic                kind;
    logic                side;
    logic [23:0]         trade_qty;
    logic [31:0]         trade_px;
    logic [31:0]         mark_px;
    logic signed [31:0]  position;
  } pdst_in_t;

  typedef struct packed {
    logic signed [47:0]  cash_pnl;
    logic signed [47:0]  open_pnl;
    logic signed [47:0]  net_pnl;
    logic signed [31:0]  held_units;
    logic [46:0]         worst_drawdown;
    logic signed [23:0]  sharpe;
    logic                is_summary;
  } pdst_out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CASH,
    ST_UNREAL,
    ST_TOTAL,
    ST_SQR,
    ST_SUM,
    ST_M_S,
    ST_DD,
    ST_ROOT,
    ST_DIV,
    ST_EMIT
  } pdst_state_e;

  function automatic logic signed [PNL_W-1:0] sat_pnl(input logic signed [63:0] v);
    logic signed [63:0] r;
    r = v;
    if (v > PNL_MAX_64) begin
      r = PNL_MAX_64;
    end else if (v < PNL_MIN_64) begin
      r = PNL_MIN_64;
    end
    return r[PNL_W-1:0];
  endfunction

endpackage

// ===== hw/rtl/pdst_wmul.sv =====
// ----------------------------------------------------------------------------
// pdst_wmul
// Shared 64x64 multiplier: four 32x32 partial products accumulated over cycles.
// ----------------------------------------------------------------------------
module pdst_wmul
  import pdst_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [63:0]  a_i,
  input  logic [63:0]  b_i,
  output logic         done_o,
  output logic [127:0] prod_o
);

  logic         busy_q;
  logic         done_q;
  logic [2:0]   k_q;
  logic [63:0]  a_q;
  logic [63:0]  b_q;
  logic [63:0]  p_q;
  logic [1:0]   sh_q;
  logic [127:0] acc_q;
  logic [31:0]  limb_a;
  logic [31:0]  limb_b;
  logic [127:0] p_ext;

  assign limb_a = k_q[1] ? a_q[63:32] : a_q[31:0];
  assign limb_b = k_q[0] ? b_q[63:32] : b_q[31:0];
  assign p_ext  = {64'd0, p_q} << {sh_q, 5'd0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      k_q    <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        k_q    <= '0;
      end else if (busy_q) begin
        k_q <= k_q + 3'd1;
        if (k_q == 3'd4) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_i;
      b_q   <= b_i;
      acc_q <= '0;
    end else if (busy_q) begin
      if (k_q != 3'd4) begin
        p_q  <= limb_a * limb_b;
        sh_q <= {1'b0, k_q[1]} + {1'b0, k_q[0]};
      end
      if (k_q != 3'd0) begin
        acc_q <= acc_q + p_ext;
      end
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

// ===== hw/rtl/pdst_sqrt.sv =====
// ----------------------------------------------------------------------------
// pdst_sqrt
// Restoring integer square root of a 128-bit value, one root bit per cycle.
// ----------------------------------------------------------------------------
module pdst_sqrt
  import pdst_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [127:0] v_i,
  output logic         done_o,
  output logic [63:0]  root_o
);

  logic         busy_q;
  logic         done_q;
  logic [5:0]   cnt_q;
  logic [127:0] v_q;
  logic [67:0]  rem_q;
  logic [63:0]  root_q;
  logic [67:0]  r2;
  logic [67:0]  trial;
  logic         ge;

  assign r2    = {rem_q[65:0], v_q[127:126]};
  assign trial = {2'b00, root_q, 2'b01};
  assign ge    = r2 >= trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'd63) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      v_q    <= v_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      v_q    <= {v_q[125:0], 2'b00};
      rem_q  <= ge ? (r2 - trial) : r2;
      root_q <= {root_q[62:0], ge};
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

// ===== hw/rtl/pdst_div.sv =====
// ----------------------------------------------------------------------------
// pdst_div
// Restoring divider for the Sharpe quotient, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pdst_div
  import pdst_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [63:0]         num_i,
  input  logic [63:0]         den_i,
  output logic                done_o,
  output logic [SHARPE_W-1:0] quo_o
);

  logic                busy_q;
  logic                done_q;
  logic [4:0]          cnt_q;
  logic [63:0]         rem_q;
  logic [87:0]         dsh_q;
  logic [SHARPE_W-1:0] quo_q;
  logic                ovf;
  logic                ge;

  assign ovf = {24'd0, num_i} >= {den_i, 24'd0};
  assign ge  = {24'd0, rem_q} >= dsh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= !ovf;
        done_q <= ovf;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'(SHARPE_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= num_i;
      dsh_q <= {1'b0, den_i, 23'd0};
      quo_q <= ovf ? SHARPE_LIM : '0;
    end else if (busy_q) begin
      rem_q <= ge ? (rem_q - dsh_q[63:0]) : rem_q;
      dsh_q <= {1'b0, dsh_q[87:1]};
      quo_q <= {quo_q[SHARPE_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

// ===== hw/rtl/pnl_drawdown_sharpe_tracker.sv =====
// ----------------------------------------------------------------------------
// pnl_drawdown_sharpe_tracker
// Running realized/unrealized PnL and peak drawdown per fill, Sharpe ratio per summary.
// ----------------------------------------------------------------------------
// One item is processed at a time; in_stall_o is high while it runs. Each
// multiply is a pass through the shared 64x64 multiplier (four 32x32 partial
// products). A fill squares its difference to the previous total, except the
// very first fill, which has no difference to square. A summary with two or
// more fills makes two multiplier passes, then runs the square-root unit and
// the divider; it ends early when the variance term is not positive or the
// root is zero, and the divider stops at once when the quotient saturates.
// With fewer fills it goes straight to output. A finished result sits in an
// output register so the next transaction is taken while it waits; a result
// that is ready while that register is still stalled holds the block until the
// register frees up.
module pnl_drawdown_sharpe_tracker
  import pdst_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  pdst_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output pdst_out_t out_data_o
);

  pdst_state_e state_q, state_d;

  pdst_in_t           item_q, item_d;
  logic signed [47:0] realized_q, realized_d;
  logic signed [47:0] unreal_q, unreal_d;
  logic signed [47:0] total_q, total_d;
  logic signed [47:0] last_total_q, last_total_d;
  logic signed [47:0] first_total_q, first_total_d;
  logic signed [47:0] peak_q, peak_d;
  logic signed [31:0] last_units_q, last_units_d;
  logic [31:0]        fill_count_q, fill_count_d;
  logic [46:0]        drawdown_q, drawdown_d;
  logic [63:0]        sq_sum_q, sq_sum_d;
  logic [127:0]       a_q, a_d;
  logic [23:0]        sharpe_q, sharpe_d;
  pdst_out_t          out_q, out_d;
  logic               out_valid_q, out_valid_d;

  logic         mul_start, mul_done;
  logic [63:0]  mul_a, mul_b;
  logic [127:0] mul_prod;
  logic         sqrt_start, sqrt_done;
  logic [127:0] sqrt_v;
  logic [63:0]  root;
  logic         div_start, div_done;
  logic [23:0]  quo;

  logic               out_free;
  logic signed [63:0] real_sum, unreal64, total64, diff64, dsum64, dd64;
  logic signed [47:0] total_sat;
  logic [63:0]        cash64;
  logic [31:0]        pos_abs;
  logic [47:0]        dmag, dm;
  logic [64:0]        sq_add;
  logic [31:0]        m_cnt;
  logic signed [47:0] peak_nx;
  logic [46:0]        dd47;
  logic [23:0]        q_pos, q_neg;

  pdst_wmul u_wmul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .prod_o  (mul_prod)
  );

  pdst_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .v_i     (sqrt_v),
    .done_o  (sqrt_done),
    .root_o  (root)
  );

  pdst_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (64'(dm) << SHARPE_FRAC),
    .den_i   (root),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    cash64    = {8'd0, mul_prod[55:0]};
    real_sum  = item_q.side ? (64'(realized_q) + $signed(cash64))
                            : (64'(realized_q) - $signed(cash64));
    unreal64  = item_q.position[31] ? -$signed({1'b0, mul_prod[62:0]})
                                    : $signed({1'b0, mul_prod[62:0]});
    total64   = 64'(realized_q) + 64'(unreal_q);
    total_sat = sat_pnl(total64);
    pos_abs   = item_q.position[31] ? (32'd0 - item_q.position) : item_q.position;
    diff64    = 64'(total_sat) - 64'(last_total_q);
    dmag      = diff64[63] ? 48'(64'd0 - diff64) : diff64[47:0];
    sq_add    = {1'b0, sq_sum_q} + {1'b0, mul_prod[79:16]};
    dsum64    = 64'(last_total_q) - 64'(first_total_q);
    dm        = dsum64[63] ? 48'(64'd0 - dsum64) : dsum64[47:0];
    m_cnt     = fill_count_q - 32'd1;
    peak_nx   = (total_q > peak_q) ? total_q : peak_q;
    dd64      = 64'(peak_nx) - 64'(total_q);
    dd47      = (dd64 > PNL_MAX_64) ? PNL_MAX_64[46:0] : dd64[46:0];
    q_pos     = (quo > SHARPE_LIM - 24'd1) ? (SHARPE_LIM - 24'd1) : quo;
    q_neg     = (quo > SHARPE_LIM) ? SHARPE_LIM : quo;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (!in_data_i.kind) begin
            state_d = ST_CASH;
          end else if (fill_count_q < 32'd2) begin
            state_d = ST_EMIT;
          end else begin
            state_d = ST_M_S;
          end
        end
      end
      ST_CASH:   if (mul_done) state_d = ST_UNREAL;
      ST_UNREAL: if (mul_done) state_d = ST_TOTAL;
      ST_TOTAL:  state_d = (fill_count_q == 32'd0) ? ST_SUM : ST_SQR;
      ST_SQR:    if (mul_done) state_d = ST_SUM;
      ST_SUM:    state_d = ST_EMIT;
      ST_M_S:    if (mul_done) state_d = ST_DD;
      ST_DD: begin
        if (mul_done) state_d = (mul_prod >= a_q) ? ST_EMIT : ST_ROOT;
      end
      ST_ROOT: begin
        if (sqrt_done) state_d = (root == 64'd0) ? ST_EMIT : ST_DIV;
      end
      ST_DIV:    if (div_done) state_d = ST_EMIT;
      ST_EMIT:   if (out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    item_d        = item_q;
    realized_d    = realized_q;
    unreal_d      = unreal_q;
    total_d       = total_q;
    last_total_d  = last_total_q;
    first_total_d = first_total_q;
    peak_d        = peak_q;
    last_units_d  = last_units_q;
    fill_count_d  = fill_count_q;
    drawdown_d    = drawdown_q;
    sq_sum_d      = sq_sum_q;
    a_d           = a_q;
    sharpe_d      = sharpe_q;
    mul_start     = 1'b0;
    mul_a         = '0;
    mul_b         = '0;
    sqrt_start    = 1'b0;
    sqrt_v        = a_q - mul_prod;
    div_start     = 1'b0;
    out_d         = out_q;
    out_valid_d   = out_valid_q && out_stall_i;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          item_d   = in_data_i;
          sharpe_d = '0;
          if (!in_data_i.kind) begin
            mul_start = 1'b1;
            mul_a     = {40'd0, in_data_i.trade_qty};
            mul_b     = {32'd0, in_data_i.trade_px};
          end else if (fill_count_q >= 32'd2) begin
            mul_start = 1'b1;
            mul_a     = {32'd0, m_cnt};
            mul_b     = sq_sum_q;
          end
        end
      end
      ST_CASH: begin
        if (mul_done) begin
          realized_d = sat_pnl(real_sum);
          mul_start  = 1'b1;
          mul_a      = {32'd0, pos_abs};
          mul_b      = {32'd0, item_q.mark_px};
        end
      end
      ST_UNREAL: begin
        if (mul_done) begin
          unreal_d = sat_pnl(unreal64);
        end
      end
      ST_TOTAL: begin
        total_d = total_sat;
        if (fill_count_q == 32'd0) begin
          first_total_d = total_sat;
        end
      end
      ST_SQR: begin
        if (mul_done) begin
          sq_sum_d = ((|mul_prod[127:80]) || sq_add[64]) ? '1 : sq_add[63:0];
        end
      end
      ST_SUM: begin
        if (fill_count_q != '1) fill_count_d = fill_count_q + 32'd1;
        last_total_d = total_q;
        last_units_d = item_q.position;
        peak_d       = peak_nx;
        if (dd47 > drawdown_q) drawdown_d = dd47;
      end
      ST_M_S: begin
        if (mul_done) begin
          a_d       = {mul_prod[111:0], 16'd0};
          mul_start = 1'b1;
          mul_a     = {16'd0, dm};
          mul_b     = {16'd0, dm};
        end
      end
      ST_DD: begin
        if (mul_done && (mul_prod < a_q)) sqrt_start = 1'b1;
      end
      ST_ROOT: begin
        if (sqrt_done && (root != 64'd0)) div_start = 1'b1;
      end
      ST_DIV: begin
        if (div_done) sharpe_d = dsum64[63] ? (24'd0 - q_neg) : q_pos;
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_d           = 1'b1;
          out_d.cash_pnl        = item_q.kind ? '0 : realized_q;
          out_d.open_pnl        = item_q.kind ? '0 : unreal_q;
          out_d.net_pnl         = last_total_q;
          out_d.held_units      = last_units_q;
          out_d.worst_drawdown  = drawdown_q;
          out_d.sharpe          = item_q.kind ? sharpe_q : '0;
          out_d.is_summary      = item_q.kind;
        end
      end
      default: ;
    endcase
    if (state_q == ST_TOTAL && fill_count_q != 32'd0) begin
      mul_start = 1'b1;
      mul_a     = {16'd0, dmag};
      mul_b     = {16'd0, dmag};
    end
  end

  // The TOTAL step squares the difference against the freshly saturated total.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      realized_q    <= '0;
      last_total_q  <= '0;
      first_total_q <= '0;
      peak_q        <= '0;
      last_units_q  <= '0;
      fill_count_q  <= '0;
      drawdown_q    <= '0;
      sq_sum_q      <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      realized_q    <= realized_d;
      last_total_q  <= last_total_d;
      first_total_q <= first_total_d;
      peak_q        <= peak_d;
      last_units_q  <= last_units_d;
      fill_count_q  <= fill_count_d;
      drawdown_q    <= drawdown_d;
      sq_sum_q      <= sq_sum_d;
      out_valid_q   <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q   <= item_d;
    unreal_q <= unreal_d;
    total_q  <= total_d;
    a_q      <= a_d;
    sharpe_q <= sharpe_d;
    out_q    <= out_d;
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_empty_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_count_q == 32'd0 |-> last_total_q == '0 && peak_q == '0 && sq_sum_q == '0)
    else $error("tracker state not clear before first fill");

  a_peak_ge_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    peak_q >= last_total_q && peak_q >= 48'sd0)
    else $error("peak total below last total");

  a_emit_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_EMIT && out_valid_q && out_stall_i |=> state_q == ST_EMIT)
    else $error("result overwritten while output stalled");

  a_fill_sharpe_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.is_summary |-> out_data_o.sharpe == '0)
    else $error("fill result carries a Sharpe value");

  a_summary_pnl_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.is_summary |->
      out_data_o.cash_pnl == '0 && out_data_o.open_pnl == '0)
    else $error("summary result carries fill PnL");

endmodule
